// ----- design/sli_pkg.sv -----
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and constants of the segment and line intersection block.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int unsigned COORD_WIDTH_DEF = 32;

    typedef enum logic {
        REQ_SEGMENT = 1'b0,
        REQ_LINE    = 1'b1
    } t_req;

    // control that travels with each item down the pipeline
    typedef struct packed {
        logic valid;
        logic hit;
        logic degz;
        logic neg_x;
        logic neg_y;
    } t_ctl;

endpackage

// ----- design/sli_req_if.sv -----
// ----------------------------------------------------------------------------
// sli_req_if
// Request channel: two lines and a mode, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sli_req_if import sli_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic signed [COORD_WIDTH-1:0] a_start_x;
    logic signed [COORD_WIDTH-1:0] a_start_y;
    logic signed [COORD_WIDTH-1:0] a_end_x;
    logic signed [COORD_WIDTH-1:0] a_end_y;
    logic signed [COORD_WIDTH-1:0] b_start_x;
    logic signed [COORD_WIDTH-1:0] b_start_y;
    logic signed [COORD_WIDTH-1:0] b_end_x;
    logic signed [COORD_WIDTH-1:0] b_end_y;

    modport source (
        output valid, req_type, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        input  ready
    );
    modport sink (
        input  valid, req_type, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        output ready
    );
endinterface

// ----- design/sli_res_if.sv -----
// ----------------------------------------------------------------------------
// sli_res_if
// Result channel: flags and intersection point, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sli_res_if import sli_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic                          degenerate;
    logic                          overflow;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;

    modport source (
        output valid, hit, degenerate, overflow, point_x, point_y,
        input  ready
    );
    modport sink (
        input  valid, hit, degenerate, overflow, point_x, point_y,
        output ready
    );
endinterface

// ----- design/sli_cross.sv -----
// ----------------------------------------------------------------------------
// sli_cross
// Four-stage cross product front end: differences, products, crosses,
// then hit test and numerator / divisor magnitudes.
// ----------------------------------------------------------------------------
module sli_cross import sli_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_req_type,
    input  logic signed [COORD_WIDTH-1:0] i_a_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_a_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_a_end_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_start_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_start_y,
    input  logic signed [COORD_WIDTH-1:0] i_b_end_x,
    input  logic signed [COORD_WIDTH-1:0] i_b_end_y,
    output t_ctl                          o_ctl,
    output logic [2*COORD_WIDTH+2:0]      o_num,
    output logic [2*COORD_WIDTH+2:0]      o_den,
    output logic signed [COORD_WIDTH-1:0] o_as_x,
    output logic signed [COORD_WIDTH-1:0] o_as_y,
    output logic signed [COORD_WIDTH:0]   o_av_x,
    output logic signed [COORD_WIDTH:0]   o_av_y
);
    localparam int unsigned W  = COORD_WIDTH;
    localparam int unsigned DW = W + 1;
    localparam int unsigned PW = 2 * DW;
    localparam int unsigned CW = PW + 1;

    logic signed [DW-1:0] asx, asy, aex, aey, bsx, bsy, bex, bey;
    logic signed [DW-1:0] n1_ux [4];
    logic signed [DW-1:0] n1_uy [4];
    logic signed [DW-1:0] n1_vx [4];
    logic signed [DW-1:0] n1_vy [4];

    logic                 r1_v, r1_mode;
    logic signed [W-1:0]  r1_asx, r1_asy;
    logic signed [DW-1:0] r1_avx, r1_avy;
    logic signed [DW-1:0] r1_ux [4];
    logic signed [DW-1:0] r1_uy [4];
    logic signed [DW-1:0] r1_vx [4];
    logic signed [DW-1:0] r1_vy [4];

    logic                 r2_v, r2_mode;
    logic signed [W-1:0]  r2_asx, r2_asy;
    logic signed [DW-1:0] r2_avx, r2_avy;
    logic signed [PW-1:0] r2_pa [4];
    logic signed [PW-1:0] r2_pb [4];

    logic                 r3_v, r3_mode;
    logic signed [W-1:0]  r3_asx, r3_asy;
    logic signed [DW-1:0] r3_avx, r3_avy;
    logic signed [CW-1:0] r3_c [4];

    logic [CW-1:0] n4_m [4];
    logic [3:0]    n4_neg, n4_pos;
    logic [CW-1:0] n4_num, n4_den;
    logic          n4_hit, n4_ndneg;

    always_comb begin
        asx = {i_a_start_x[W-1], i_a_start_x};
        asy = {i_a_start_y[W-1], i_a_start_y};
        aex = {i_a_end_x[W-1], i_a_end_x};
        aey = {i_a_end_y[W-1], i_a_end_y};
        bsx = {i_b_start_x[W-1], i_b_start_x};
        bsy = {i_b_start_y[W-1], i_b_start_y};
        bex = {i_b_end_x[W-1], i_b_end_x};
        bey = {i_b_end_y[W-1], i_b_end_y};
        // segment: (av, bs-as) (av, be-as) (bv, as-bs) (bv, ae-bs)
        n1_ux[0] = aex - asx;  n1_uy[0] = aey - asy;
        n1_vx[0] = bsx - asx;  n1_vy[0] = bsy - asy;
        n1_ux[1] = aex - asx;  n1_uy[1] = aey - asy;
        n1_vx[1] = bex - asx;  n1_vy[1] = bey - asy;
        n1_ux[2] = bex - bsx;  n1_uy[2] = bey - bsy;
        n1_vx[2] = asx - bsx;  n1_vy[2] = asy - bsy;
        n1_ux[3] = bex - bsx;  n1_uy[3] = bey - bsy;
        n1_vx[3] = aex - bsx;  n1_vy[3] = aey - bsy;
        if (i_req_type == REQ_LINE) begin
            // line: numerator (bv, bs-as), divisor (bv, av)
            n1_ux[0] = bex - bsx;  n1_uy[0] = bey - bsy;
            n1_vx[0] = bsx - asx;  n1_vy[0] = bsy - asy;
            n1_ux[1] = bex - bsx;  n1_uy[1] = bey - bsy;
            n1_vx[1] = aex - asx;  n1_vy[1] = aey - asy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r3_v     <= 1'b0;
            o_ctl.valid <= 1'b0;
        end else if (i_en) begin
            r1_v     <= i_valid;
            r2_v     <= r1_v;
            r3_v     <= r2_v;
            o_ctl.valid <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mode <= i_req_type;
            r1_asx  <= i_a_start_x;
            r1_asy  <= i_a_start_y;
            r1_avx  <= aex - asx;
            r1_avy  <= aey - asy;
            for (int k = 0; k < 4; k++) begin
                r1_ux[k] <= n1_ux[k];
                r1_uy[k] <= n1_uy[k];
                r1_vx[k] <= n1_vx[k];
                r1_vy[k] <= n1_vy[k];
            end

            r2_mode <= r1_mode;
            r2_asx  <= r1_asx;
            r2_asy  <= r1_asy;
            r2_avx  <= r1_avx;
            r2_avy  <= r1_avy;
            for (int k = 0; k < 4; k++) begin
                r2_pa[k] <= r1_ux[k] * r1_vy[k];
                r2_pb[k] <= r1_uy[k] * r1_vx[k];
            end

            r3_mode <= r2_mode;
            r3_asx  <= r2_asx;
            r3_asy  <= r2_asy;
            r3_avx  <= r2_avx;
            r3_avy  <= r2_avy;
            for (int k = 0; k < 4; k++) begin
                r3_c[k] <= CW'(r2_pa[k]) - CW'(r2_pb[k]);
            end

            o_ctl.hit   <= n4_hit;
            o_ctl.degz  <= (n4_den == '0);
            o_ctl.neg_x <= n4_ndneg;
            o_ctl.neg_y <= n4_ndneg;
            o_num       <= n4_num;
            o_den       <= n4_den;
            o_as_x      <= r3_asx;
            o_as_y      <= r3_asy;
            o_av_x      <= r3_avx;
            o_av_y      <= r3_avy;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n4_neg[k] = r3_c[k][CW-1];
            n4_pos[k] = !r3_c[k][CW-1] && (r3_c[k] != '0);
            n4_m[k]   = r3_c[k][CW-1] ? CW'(-r3_c[k]) : CW'(r3_c[k]);
        end
        if (r3_mode == REQ_LINE) begin
            n4_num   = n4_m[0];
            n4_den   = n4_m[1];
            n4_hit   = (r3_c[1] != '0);
            n4_ndneg = n4_neg[0] ^ n4_neg[1];
        end else begin
            n4_num   = n4_m[2];
            n4_den   = n4_m[2] + n4_m[3];
            n4_hit   = !((n4_pos[0] && n4_pos[1]) || (n4_neg[0] && n4_neg[1]))
                    && !((n4_pos[2] && n4_pos[3]) || (n4_neg[2] && n4_neg[3]));
            n4_ndneg = 1'b0;
        end
    end

endmodule

// ----- design/sli_scale.sv -----
// ----------------------------------------------------------------------------
// sli_scale
// Two-stage scaling of the direction vector by the numerator magnitude,
// split into two partial products per coordinate.
// ----------------------------------------------------------------------------
module sli_scale import sli_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  t_ctl                          i_ctl,
    input  logic [2*COORD_WIDTH+2:0]      i_num,
    input  logic [2*COORD_WIDTH+2:0]      i_den,
    input  logic signed [COORD_WIDTH-1:0] i_as_x,
    input  logic signed [COORD_WIDTH-1:0] i_as_y,
    input  logic signed [COORD_WIDTH:0]   i_av_x,
    input  logic signed [COORD_WIDTH:0]   i_av_y,
    output t_ctl                          o_ctl,
    output logic [3*COORD_WIDTH+3:0]      o_px,
    output logic [3*COORD_WIDTH+3:0]      o_py,
    output logic [2*COORD_WIDTH+2:0]      o_den,
    output logic signed [COORD_WIDTH-1:0] o_as_x,
    output logic signed [COORD_WIDTH-1:0] o_as_y
);
    localparam int unsigned W   = COORD_WIDTH;
    localparam int unsigned DW  = W + 1;
    localparam int unsigned MW  = 2 * W + 3;
    localparam int unsigned PRW = DW + MW;
    localparam int unsigned NL  = (MW + 1) / 2;
    localparam int unsigned NH  = MW - NL;

    logic [DW-1:0] avm_x, avm_y;

    t_ctl                 r5_ctl;
    logic [NL+DW-1:0]     r5_lo_x, r5_lo_y;
    logic [NH+DW-1:0]     r5_hi_x, r5_hi_y;
    logic [MW-1:0]        r5_den;
    logic signed [W-1:0]  r5_asx, r5_asy;

    always_comb begin
        avm_x = i_av_x[DW-1] ? DW'(-i_av_x) : DW'(i_av_x);
        avm_y = i_av_y[DW-1] ? DW'(-i_av_y) : DW'(i_av_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_ctl.valid <= 1'b0;
            o_ctl.valid  <= 1'b0;
        end else if (i_en) begin
            r5_ctl.valid <= i_ctl.valid;
            o_ctl.valid  <= r5_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_ctl.hit   <= i_ctl.hit;
            r5_ctl.degz  <= i_ctl.degz;
            r5_ctl.neg_x <= i_ctl.neg_x ^ i_av_x[DW-1];
            r5_ctl.neg_y <= i_ctl.neg_y ^ i_av_y[DW-1];
            r5_lo_x      <= i_num[NL-1:0] * avm_x;
            r5_lo_y      <= i_num[NL-1:0] * avm_y;
            r5_hi_x      <= i_num[MW-1:NL] * avm_x;
            r5_hi_y      <= i_num[MW-1:NL] * avm_y;
            r5_den       <= i_den;
            r5_asx       <= i_as_x;
            r5_asy       <= i_as_y;

            o_ctl.hit    <= r5_ctl.hit;
            o_ctl.degz   <= r5_ctl.degz;
            o_ctl.neg_x  <= r5_ctl.neg_x;
            o_ctl.neg_y  <= r5_ctl.neg_y;
            o_px         <= PRW'(r5_lo_x) + (PRW'(r5_hi_x) << NL);
            o_py         <= PRW'(r5_lo_y) + (PRW'(r5_hi_y) << NL);
            o_den        <= r5_den;
            o_as_x       <= r5_asx;
            o_as_y       <= r5_asy;
        end
    end

endmodule

// ----- design/sli_div.sv -----
// ----------------------------------------------------------------------------
// sli_div
// Pipelined restoring divider, one quotient bit per stage, with a range
// pre-check, followed by the offset add and saturation stage.
// ----------------------------------------------------------------------------
module sli_div import sli_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  t_ctl                          i_ctl,
    input  logic [3*COORD_WIDTH+3:0]      i_px,
    input  logic [3*COORD_WIDTH+3:0]      i_py,
    input  logic [2*COORD_WIDTH+2:0]      i_den,
    input  logic signed [COORD_WIDTH-1:0] i_as_x,
    input  logic signed [COORD_WIDTH-1:0] i_as_y,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic                          o_degz,
    output logic                          o_ov,
    output logic signed [COORD_WIDTH-1:0] o_px,
    output logic signed [COORD_WIDTH-1:0] o_py
);
    localparam int unsigned W   = COORD_WIDTH;
    localparam int unsigned QW  = W + 1;
    localparam int unsigned MW  = 2 * W + 3;
    localparam int unsigned PRW = QW + MW;
    localparam int unsigned SW  = W + 3;

    t_ctl                r_ctl  [QW+1];
    logic [MW-1:0]       r_den  [QW+1];
    logic signed [W-1:0] r_asx  [QW+1];
    logic signed [W-1:0] r_asy  [QW+1];
    logic [MW-1:0]       r_remx [QW+1];
    logic [MW-1:0]       r_remy [QW+1];
    logic [QW-1:0]       r_lowx [QW+1];
    logic [QW-1:0]       r_lowy [QW+1];
    logic [QW-1:0]       r_qx   [QW+1];
    logic [QW-1:0]       r_qy   [QW+1];
    logic                r_bigx [QW+1];
    logic                r_bigy [QW+1];

    logic [W:0] fx, fy;

    // quotient magnitude at or above 2^QW always saturates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl[0].valid <= 1'b0;
        end else if (i_en) begin
            r_ctl[0].valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl[0].hit   <= i_ctl.hit;
            r_ctl[0].degz  <= i_ctl.degz;
            r_ctl[0].neg_x <= i_ctl.neg_x;
            r_ctl[0].neg_y <= i_ctl.neg_y;
            r_den[0]       <= i_den;
            r_asx[0]       <= i_as_x;
            r_asy[0]       <= i_as_y;
            r_remx[0]      <= i_px[PRW-1:QW];
            r_remy[0]      <= i_py[PRW-1:QW];
            r_lowx[0]      <= i_px[QW-1:0];
            r_lowy[0]      <= i_py[QW-1:0];
            r_qx[0]        <= '0;
            r_qy[0]        <= '0;
            r_bigx[0]      <= (i_px[PRW-1:QW] >= i_den);
            r_bigy[0]      <= (i_py[PRW-1:QW] >= i_den);
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [MW:0] tx, ty;
        logic        gex, gey;

        always_comb begin
            tx  = {r_remx[k], r_lowx[k][QW-1]};
            ty  = {r_remy[k], r_lowy[k][QW-1]};
            gex = (tx >= {1'b0, r_den[k]});
            gey = (ty >= {1'b0, r_den[k]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k+1].valid <= 1'b0;
            end else if (i_en) begin
                r_ctl[k+1].valid <= r_ctl[k].valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctl[k+1].hit   <= r_ctl[k].hit;
                r_ctl[k+1].degz  <= r_ctl[k].degz;
                r_ctl[k+1].neg_x <= r_ctl[k].neg_x;
                r_ctl[k+1].neg_y <= r_ctl[k].neg_y;
                r_den[k+1]       <= r_den[k];
                r_asx[k+1]       <= r_asx[k];
                r_asy[k+1]       <= r_asy[k];
                r_bigx[k+1]      <= r_bigx[k];
                r_bigy[k+1]      <= r_bigy[k];
                r_remx[k+1]      <= gex ? MW'(tx - {1'b0, r_den[k]}) : tx[MW-1:0];
                r_remy[k+1]      <= gey ? MW'(ty - {1'b0, r_den[k]}) : ty[MW-1:0];
                r_lowx[k+1]      <= {r_lowx[k][QW-2:0], 1'b0};
                r_lowy[k+1]      <= {r_lowy[k][QW-2:0], 1'b0};
                r_qx[k+1]        <= {r_qx[k][QW-2:0], gex};
                r_qy[k+1]        <= {r_qy[k][QW-2:0], gey};
            end
        end
    end

    // returns {saturated, coordinate}
    function automatic logic [W:0] f_place(
        input logic [QW-1:0]      q,
        input logic               neg,
        input logic               big,
        input logic signed [W-1:0] st
    );
        logic signed [SW-1:0] qs;
        logic signed [SW-1:0] s;
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        logic [W:0]           res;
        hi = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
        lo = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};
        qs = signed'(SW'(q));
        if (neg) begin
            qs = -qs;
        end
        s = SW'(st) + qs;
        if (big) begin
            res = neg ? {1'b1, lo[W-1:0]} : {1'b1, hi[W-1:0]};
        end else if (s > hi) begin
            res = {1'b1, hi[W-1:0]};
        end else if (s < lo) begin
            res = {1'b1, lo[W-1:0]};
        end else begin
            res = {1'b0, s[W-1:0]};
        end
        return res;
    endfunction

    always_comb begin
        fx = f_place(r_qx[QW], r_ctl[QW].neg_x, r_bigx[QW], r_asx[QW]);
        fy = f_place(r_qy[QW], r_ctl[QW].neg_y, r_bigy[QW], r_asy[QW]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_ctl[QW].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_hit  <= r_ctl[QW].hit;
            o_degz <= r_ctl[QW].degz;
            o_ov   <= !r_ctl[QW].degz && (fx[W] || fy[W]);
            o_px   <= r_ctl[QW].degz ? '0 : fx[W-1:0];
            o_py   <= r_ctl[QW].degz ? '0 : fy[W-1:0];
        end
    end

endmodule

// ----- design/sli_skid.sv -----
// ----------------------------------------------------------------------------
// sli_skid
// Two-entry output buffer: output register plus skid register. The
// pipeline advances whenever the skid register is empty.
// ----------------------------------------------------------------------------
module sli_skid import sli_pkg::*; #(
    parameter int unsigned DATA_WIDTH = 2 * COORD_WIDTH_DEF + 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [DATA_WIDTH-1:0] i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [DATA_WIDTH-1:0] o_data
);
    logic                  r_out_v, r_skid_v;
    logic [DATA_WIDTH-1:0] r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (i_ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || i_ready) begin
            r_out_v <= i_valid;
        end else if (i_valid) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || i_ready) begin
            r_out <= i_data;
        end else begin
            r_skid <= i_data;
        end
    end

    assign o_full  = r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry held without output entry");
    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !i_ready && i_valid && !r_skid_v) |=> r_skid_v)
        else $error("stalled transfer not captured in skid");
    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_ready) |=> (r_out_v && !r_skid_v))
        else $error("skid entry not moved to output");
`endif

endmodule

// ----- design/segment_and_line_intersection_top.sv -----
// ----------------------------------------------------------------------------
// segment_and_line_intersection_top
// Segment and line intersection of two lines in signed fixed point.
//
//   channel  dir  handshake            payload
//   i_req    in   valid/ready          req_type, A and B endpoints
//   o_res    out  valid/ready          hit, degenerate, overflow, point
//
// One transfer per cycle in and out while o_res is ready. Results pass
// the cross, scale and divider stages, one quotient bit per divider stage.
// i_rst_n is synchronous and clears only the valid bits.
// A two-entry output buffer holds results; i_req.ready drops only while
// both entries are full, and then the whole pipeline holds.
// ----------------------------------------------------------------------------
module segment_and_line_intersection_top import sli_pkg::*; #(
    parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sli_req_if.sink   i_req,
    sli_res_if.source o_res
);
    localparam int unsigned W  = COORD_WIDTH;
    localparam int unsigned RW = 2 * W + 3;

    logic                 en, full;
    t_ctl                 c_ctl, s_ctl;
    logic [2*W+2:0]       c_num, c_den, s_den;
    logic signed [W-1:0]  c_asx, c_asy, s_asx, s_asy;
    logic signed [W:0]    c_avx, c_avy;
    logic [3*W+3:0]       s_px, s_py;
    logic                 d_valid, d_hit, d_degz, d_ov;
    logic signed [W-1:0]  d_px, d_py;
    logic [RW-1:0]        res_data;

    assign en          = !full;
    assign i_req.ready = en;

    sli_cross #(.COORD_WIDTH(W)) u_cross (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_a_start_x (i_req.a_start_x),
        .i_a_start_y (i_req.a_start_y),
        .i_a_end_x   (i_req.a_end_x),
        .i_a_end_y   (i_req.a_end_y),
        .i_b_start_x (i_req.b_start_x),
        .i_b_start_y (i_req.b_start_y),
        .i_b_end_x   (i_req.b_end_x),
        .i_b_end_y   (i_req.b_end_y),
        .o_ctl       (c_ctl),
        .o_num       (c_num),
        .o_den       (c_den),
        .o_as_x      (c_asx),
        .o_as_y      (c_asy),
        .o_av_x      (c_avx),
        .o_av_y      (c_avy)
    );

    sli_scale #(.COORD_WIDTH(W)) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (c_ctl),
        .i_num   (c_num),
        .i_den   (c_den),
        .i_as_x  (c_asx),
        .i_as_y  (c_asy),
        .i_av_x  (c_avx),
        .i_av_y  (c_avy),
        .o_ctl   (s_ctl),
        .o_px    (s_px),
        .o_py    (s_py),
        .o_den   (s_den),
        .o_as_x  (s_asx),
        .o_as_y  (s_asy)
    );

    sli_div #(.COORD_WIDTH(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (s_ctl),
        .i_px    (s_px),
        .i_py    (s_py),
        .i_den   (s_den),
        .i_as_x  (s_asx),
        .i_as_y  (s_asy),
        .o_valid (d_valid),
        .o_hit   (d_hit),
        .o_degz  (d_degz),
        .o_ov    (d_ov),
        .o_px    (d_px),
        .o_py    (d_py)
    );

    sli_skid #(.DATA_WIDTH(RW)) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .i_data  ({d_hit, d_degz, d_ov, d_px, d_py}),
        .o_full  (full),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_data  (res_data)
    );

    assign o_res.hit        = res_data[RW-1];
    assign o_res.degenerate = res_data[RW-2];
    assign o_res.overflow   = res_data[RW-3];
    assign o_res.point_x    = res_data[2*W-1:W];
    assign o_res.point_y    = res_data[W-1:0];

endmodule

// ----- bench/sli_checker.sv -----
// ----------------------------------------------------------------------------
// sli_checker
// Watches the request and result channels of the intersection block, works
// out the expected flags and point of every request transfer with exact wide
// arithmetic, and compares each result transfer with the oldest expectation.
// ----------------------------------------------------------------------------
module sli_checker import sli_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sli_req_if   i_req,
    sli_res_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);
    typedef logic signed [159:0] t_wide;

    typedef struct packed {
        logic        hit;
        logic        degenerate;
        logic        overflow;
        logic [31:0] point_x;
        logic [31:0] point_y;
    } t_crossing;

    t_crossing crossing_q[$];

    function automatic t_wide cross_prod(t_wide ux, t_wide uy, t_wide vx, t_wide vy);
        return ux * vy - uy * vx;
    endfunction

    function automatic int sign_of(t_wide v);
        return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
    endfunction

    function automatic t_wide mag(t_wide v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [31:0] place_coord(t_wide start, t_wide vec, t_wide num,
                                                t_wide den, inout logic ov);
        t_wide r;
        t_wide hi;
        t_wide lo;
        hi = 160'sh7FFF_FFFF;
        lo = -hi - 1;
        r  = start + (vec * num) / den;
        if (r < lo) begin
            ov = 1'b1;
            r  = lo;
        end else if (r > hi) begin
            ov = 1'b1;
            r  = hi;
        end
        return r[31:0];
    endfunction

    function automatic t_crossing predict_crossing(t_req op, t_wide asx, t_wide asy,
                                                   t_wide aex, t_wide aey, t_wide bsx,
                                                   t_wide bsy, t_wide bex, t_wide bey);
        t_crossing res;
        t_wide avx, avy, bvx, bvy, num, den, c1, c2, c3, c4;
        logic ov;
        avx = aex - asx;
        avy = aey - asy;
        bvx = bex - bsx;
        bvy = bey - bsy;
        ov  = 1'b0;
        res = '0;
        if (op == REQ_SEGMENT) begin
            c1 = cross_prod(avx, avy, bsx - asx, bsy - asy);
            c2 = cross_prod(avx, avy, bex - asx, bey - asy);
            c3 = cross_prod(bvx, bvy, asx - bsx, asy - bsy);
            c4 = cross_prod(bvx, bvy, aex - bsx, aey - bsy);
            res.hit = (sign_of(c1) * sign_of(c2) <= 0) && (sign_of(c3) * sign_of(c4) <= 0);
            num = mag(c3);
            den = mag(c3) + mag(c4);
        end else begin
            res.hit = cross_prod(avx, avy, bvx, bvy) != 0;
            num = cross_prod(bvx, bvy, bsx - asx, bsy - asy);
            den = cross_prod(bvx, bvy, avx, avy);
        end
        res.degenerate = (den == 0);
        if (den != 0) begin
            res.point_x = place_coord(asx, avx, num, den, ov);
            res.point_y = place_coord(asy, avy, num, den, ov);
        end
        res.overflow = ov;
        return res;
    endfunction

    initial o_fail_count = 0;
    assign o_pending = crossing_q.size();

    always @(posedge i_clk) begin
        t_crossing want;
        int        errs;
        errs = 0;
        if (i_rst_n) begin
            if (i_req.valid && i_req.ready) begin
                crossing_q.push_back(predict_crossing(t_req'(i_req.req_type),
                    i_req.a_start_x, i_req.a_start_y, i_req.a_end_x, i_req.a_end_y,
                    i_req.b_start_x, i_req.b_start_y, i_req.b_end_x, i_req.b_end_y));
            end
            if (i_res.valid && i_res.ready) begin
                if (crossing_q.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    errs++;
                end else begin
                    want = crossing_q.pop_front();
                    if (i_res.hit !== want.hit) begin
                        $error("hit: expected %0b, got %0b", want.hit, i_res.hit);
                        errs++;
                    end
                    if (i_res.degenerate !== want.degenerate) begin
                        $error("degenerate: expected %0b, got %0b", want.degenerate,
                               i_res.degenerate);
                        errs++;
                    end
                    if (i_res.overflow !== want.overflow) begin
                        $error("overflow: expected %0b, got %0b", want.overflow,
                               i_res.overflow);
                        errs++;
                    end
                    if (i_res.point_x !== want.point_x) begin
                        $error("point_x: expected %h, got %h", want.point_x, i_res.point_x);
                        errs++;
                    end
                    if (i_res.point_y !== want.point_y) begin
                        $error("point_y: expected %h, got %h", want.point_y, i_res.point_y);
                        errs++;
                    end
                end
            end
            if (errs > 0) begin
                o_fail_count <= o_fail_count + errs;
            end
        end
    end
endmodule

// ----- bench/tb_segment_and_line_intersection_top.sv -----
// ----------------------------------------------------------------------------
// tb_segment_and_line_intersection_top
// Drives directed and random line pairs in both modes into the intersection
// block with random gaps and result stalls, including one long stall that
// backs up the pipeline; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_segment_and_line_intersection_top import sli_pkg::*;;

    localparam int N_RANDOM = 1500;
    localparam logic [31:0] CMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] CMIN = 32'h8000_0000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   results_seen;

    sli_req_if req_ch ();
    sli_res_if res_ch ();

    segment_and_line_intersection_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    sli_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic send_pair(t_req op, logic [31:0] asx, logic [31:0] asy,
                             logic [31:0] aex, logic [31:0] aey, logic [31:0] bsx,
                             logic [31:0] bsy, logic [31:0] bex, logic [31:0] bey,
                             bit calm);
        int gap;
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= op;
        req_ch.a_start_x <= asx;
        req_ch.a_start_y <= asy;
        req_ch.a_end_x   <= aex;
        req_ch.a_end_y   <= aey;
        req_ch.b_start_x <= bsx;
        req_ch.b_start_y <= bsy;
        req_ch.b_end_x   <= bex;
        req_ch.b_end_y   <= bey;
        do @(posedge i_clk); while (!req_ch.ready);
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_coord(int kind);
        case (kind)
            0:       return $urandom;
            1:       return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            2: begin
                case ($urandom_range(0, 3))
                    0:       return CMAX;
                    1:       return CMIN;
                    2:       return 32'h0;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom_range(0, 64) - 32;
        endcase
    endfunction

    initial begin
        int k;
        int kind;
        t_req op;
        logic [31:0] p[8];
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_SEGMENT;
        req_ch.a_start_x = '0;
        req_ch.a_start_y = '0;
        req_ch.a_end_x   = '0;
        req_ch.a_end_y   = '0;
        req_ch.b_start_x = '0;
        req_ch.b_start_y = '0;
        req_ch.b_end_x   = '0;
        req_ch.b_end_y   = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: crossing, touching, parallel, collinear, zero-length, extremes
        for (k = 0; k < 2; k++) begin
            op = t_req'(k);
            send_pair(op, 0, 0, 32'h40000, 32'h40000, 0, 32'h40000, 32'h40000, 0, 0);
            send_pair(op, 0, 0, 32'h10000, 0, 32'h10000, 0, 32'h10000, 32'h10000, 0);
            send_pair(op, 0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h10000, 0);
            send_pair(op, 0, 0, 32'h20000, 0, 32'h10000, 0, 32'h30000, 0, 0);
            send_pair(op, 0, 0, 0, 0, 0, 0, 0, 0, 0);
            send_pair(op, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, 1);
            send_pair(op, CMAX, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, 1);
            send_pair(op, 0, 0, 32'h10000, 0, 32'h7000_0000, 1, 32'h7000_0001, 2, 0);
            send_pair(op, 0, 0, 1, 0, 0, 32'h10000, 1, 32'h10001, 0);
            send_pair(op, CMIN, 0, CMAX, 1, CMIN, 1, CMAX, 0, 0);
            send_pair(op, 32'hFFFF_FFFF, 5, 32'h5, 32'hFFFF_FFFB, 0, 0, 32'h10, 0, 0);
        end

        for (k = 0; k < N_RANDOM; k++) begin
            kind = $urandom_range(0, 9);
            op   = t_req'($urandom_range(0, 1));
            foreach (p[i]) p[i] = rand_coord((kind < 2) ? 0 : (kind < 7) ? 1 :
                                             (kind < 8) ? $urandom_range(0, 3) : 3);
            if (kind == 9) begin
                // parallel or collinear pair
                p[4] = p[0] + $urandom_range(0, 8);
                p[5] = p[1];
                p[6] = p[4] + (p[2] - p[0]);
                p[7] = p[5] + (p[3] - p[1]);
            end
            send_pair(op, p[0], p[1], p[2], p[3], p[4], p[5], p[6], p[7], (k / 150) % 3 == 1);
        end
        req_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        int stall;
        res_ch.ready = 1'b0;
        results_seen = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (results_seen == 300) begin
                stall = 1000;
            end else if ((results_seen / 200) % 3 == 2) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 15);
            end
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            results_seen++;
        end
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
